// File: rtl/fcbs_pkg.sv
// Shared types, constants and pattern/condition tables of the fault code blink sequencer.
package fcbs_pkg;

   // Code steps: codes 1..17 blink, step 18 wraps back to code 1
   localparam int CodeCount = 17;
   localparam logic [4:0] WrapStep = 5'd18;
   localparam logic [4:0] FirstCode = 5'd1;

   // Reset values of the timing registers
   localparam logic [15:0] ZeroOnLimitReset = 16'd20;
   localparam logic [15:0] ZeroOffLimitReset = 16'd40;
   localparam logic [15:0] OneOnLimitReset = 16'd40;
   localparam logic [15:0] OneEndCountReset = 16'd60;
   localparam logic [15:0] GapEndCountReset = 16'd50;

   // Register index on the CSR port (byte address / 4)
   typedef enum logic [2:0] {
      CSR_ZERO_ON_LIMIT  = 3'd0,
      CSR_ZERO_OFF_LIMIT = 3'd1,
      CSR_ONE_ON_LIMIT   = 3'd2,
      CSR_ONE_END_COUNT  = 3'd3,
      CSR_GAP_END_COUNT  = 3'd4
   } csr_index_type;

   // Timing limits handed to the step logic
   typedef struct packed {
      logic [15:0] zero_on_limit;
      logic [15:0] zero_off_limit;
      logic [15:0] one_on_limit;
      logic [15:0] one_end_count;
      logic [15:0] gap_end_count;
   } cfg_type;

   // Blink pattern of a code, LSB is sent first; 0 = short, 1 = long
   function automatic logic [3:0] pattern_bits(input logic [4:0] code);
      logic [3:0] bits;
      unique case (code)
         5'd1:    bits = 4'd0;
         5'd2:    bits = 4'd4;
         5'd3:    bits = 4'd3;
         5'd4:    bits = 4'd6;
         5'd5:    bits = 4'd2;
         5'd6:    bits = 4'd1;
         5'd7:    bits = 4'd5;
         5'd8:    bits = 4'd3;
         5'd9:    bits = 4'd0;
         5'd10:   bits = 4'd8;
         5'd11:   bits = 4'd4;
         5'd12:   bits = 4'd12;
         5'd13:   bits = 4'd2;
         5'd14:   bits = 4'd10;
         5'd15:   bits = 4'd6;
         5'd16:   bits = 4'd14;
         5'd17:   bits = 4'd1;
         default: bits = 4'd0;
      endcase
      return bits;
   endfunction

   // Pattern length: three bits for codes 1..8, four for codes 9..17
   function automatic logic [2:0] pattern_len(input logic [4:0] code);
      return (code <= 5'd8) ? 3'd3 : 3'd4;
   endfunction

   // Fault condition of each code
   function automatic logic fault_present(input logic [4:0] code, input logic [17:0] f);
      logic hit;
      unique case (code)
         5'd1:    hit = f[0];
         5'd2:    hit = f[1] & ~f[2];
         5'd3:    hit = f[1] & f[2];
         5'd4:    hit = f[3];
         5'd5:    hit = f[4];
         5'd6:    hit = f[5];
         5'd7:    hit = f[6];
         5'd8:    hit = f[7];
         5'd9:    hit = f[8] & f[9];
         5'd10:   hit = f[8] & f[10];
         5'd11:   hit = f[8] & f[11];
         5'd12:   hit = f[12];
         5'd13:   hit = f[8] & f[13];
         5'd14:   hit = f[8] & f[14];
         5'd15:   hit = f[15];
         5'd16:   hit = f[16];
         5'd17:   hit = f[17];
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// File: rtl/fcbs_step.sv
// Sequencer state and the per-tick step logic of the fault code blink sequencer.
module fcbs_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [17:0]      fault_flags,
   input  fcbs_pkg::cfg_type cfg,
   output logic             led_next,
   output logic [4:0]       code_now
);
   import fcbs_pkg::*;

   logic [4:0]  code_step_ff, code_step_in;
   logic [2:0]  bit_position_ff, bit_position_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        led_state_ff, led_state_in;

   logic        code_ok;
   logic        fault_hit;
   logic [3:0]  pat;
   logic [2:0]  len;
   logic [15:0] cnt;
   logic        cur_bit;

   assign code_ok   = (code_step_ff >= FirstCode) && (code_step_ff <= 5'(CodeCount));
   assign fault_hit = fault_present(code_step_ff, fault_flags);
   assign pat       = pattern_bits(code_step_ff);
   assign len       = pattern_len(code_step_ff);
   assign cnt       = tick_count_ff + 16'd1;
   assign cur_bit   = pat[bit_position_ff[1:0]];

   // One phase per tick: blink a bit, wait the gap, skip, or wrap
   always_comb begin
      code_step_in    = code_step_ff;
      bit_position_in = bit_position_ff;
      tick_count_in   = tick_count_ff;
      led_state_in    = led_state_ff;
      if (fire) begin
         if (!code_ok) begin
            // wrap step clears progress, LED kept
            code_step_in    = FirstCode;
            bit_position_in = 3'd0;
            tick_count_in   = 16'd0;
         end else if (!fault_hit) begin
            // skip keeps blink progress
            code_step_in = code_step_ff + 5'd1;
         end else begin
            tick_count_in = cnt;
            if (bit_position_ff < len) begin
               if (!cur_bit) begin
                  if (cnt <= cfg.zero_on_limit) led_state_in = 1'b1;
                  if (cnt > cfg.zero_on_limit && cnt <= cfg.zero_off_limit) begin
                     led_state_in = 1'b0;
                  end
                  if (cnt > cfg.zero_off_limit) begin
                     tick_count_in   = 16'd0;
                     bit_position_in = bit_position_ff + 3'd1;
                  end
               end else begin
                  if (cnt < cfg.one_on_limit) led_state_in = 1'b1;
                  if (cnt >= cfg.one_on_limit && cnt < cfg.one_end_count) begin
                     led_state_in = 1'b0;
                  end
                  if (cnt >= cfg.one_end_count) begin
                     tick_count_in   = 16'd0;
                     bit_position_in = bit_position_ff + 3'd1;
                  end
               end
            end else if (cnt >= cfg.gap_end_count) begin
               // gap done, next code
               tick_count_in   = 16'd0;
               bit_position_in = 3'd0;
               code_step_in    = code_step_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_step_ff    <= FirstCode;
         bit_position_ff <= 3'd0;
         tick_count_ff   <= 16'd0;
         led_state_ff    <= 1'b0;
      end else begin
         code_step_ff    <= code_step_in;
         bit_position_ff <= bit_position_in;
         tick_count_ff   <= tick_count_in;
         led_state_ff    <= led_state_in;
      end
   end

   assign led_next = led_state_in;
   assign code_now = code_step_ff;

   // Code step stays within 1..18
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      (code_step_ff >= FirstCode) && (code_step_ff <= WrapStep))
      else $error("code step out of range");

   // Bit position never runs past the longest pattern
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_position_ff <= 3'd4)
      else $error("bit position past pattern end");

   // A skip leaves blink progress untouched
   a_skip_keeps: assert property (@(posedge clock) disable iff (reset)
      (fire && code_ok && !fault_hit) |=>
         ($stable(tick_count_ff) && $stable(bit_position_ff) && $stable(led_state_ff)))
      else $error("skip changed blink progress");

endmodule

// File: rtl/fault_code_blink_sequencer_top.sv
// Top level of the fault code blink sequencer: handshake stages, CSR block and step logic.
//
// Usage:
//   req_* carries one timer tick per transaction with the raw fault flag vector.
//   rsp_* returns exactly one transaction per tick: the LED state after that tick
//   and the code step that was handled in it.
//   csr_* is an APB-style port holding five 16-bit timing registers at byte
//   addresses 0, 4, 8, 12, 16; write them only while no tick is in flight.
// Flow: an accepted tick waits in the input register, the step logic handles it when
//   the result register is free, and its result is held there until it is taken.
// Throughput: one tick per cycle while rsp_stall is low; the step logic is a single
//   compare/select pass between the input register and the result register.
// Stall: when rsp_stall holds, the result register holds; one more tick is taken
//   into the input register if it is empty, then req_stall rises until the result is taken.
// Reset: synchronous; code step 1, counters cleared, LED off, registers to defaults.
module fault_code_blink_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [17:0] req_fault_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_led_on,
   output logic [4:0]  rsp_code_number,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fcbs_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [17:0] s1_flags_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_led_ff;
   logic [4:0]  rsp_code_ff;
   logic        out_free;
   logic        fire;
   logic        req_take;
   logic        led_next;
   logic [4:0]  code_now;
   cfg_type     cfg_ff, cfg_in;
   logic        csr_write;
   csr_index_type csr_index;

   // Handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) s1_flags_ff <= req_fault_flags;
      if (fire) begin
         rsp_led_ff  <= led_next;
         rsp_code_ff <= code_now;
      end
   end

   fcbs_step u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .fault_flags (s1_flags_ff),
      .cfg         (cfg_ff),
      .led_next    (led_next),
      .code_now    (code_now)
   );

   // CSR write decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ZERO_ON_LIMIT:  cfg_in.zero_on_limit  = csr_pwdata[15:0];
            CSR_ZERO_OFF_LIMIT: cfg_in.zero_off_limit = csr_pwdata[15:0];
            CSR_ONE_ON_LIMIT:   cfg_in.one_on_limit   = csr_pwdata[15:0];
            CSR_ONE_END_COUNT:  cfg_in.one_end_count  = csr_pwdata[15:0];
            CSR_GAP_END_COUNT:  cfg_in.gap_end_count  = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_on_limit  <= ZeroOnLimitReset;
         cfg_ff.zero_off_limit <= ZeroOffLimitReset;
         cfg_ff.one_on_limit   <= OneOnLimitReset;
         cfg_ff.one_end_count  <= OneEndCountReset;
         cfg_ff.gap_end_count  <= GapEndCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // CSR read mux
   always_comb begin
      unique case (csr_index)
         CSR_ZERO_ON_LIMIT:  csr_prdata = {16'd0, cfg_ff.zero_on_limit};
         CSR_ZERO_OFF_LIMIT: csr_prdata = {16'd0, cfg_ff.zero_off_limit};
         CSR_ONE_ON_LIMIT:   csr_prdata = {16'd0, cfg_ff.one_on_limit};
         CSR_ONE_END_COUNT:  csr_prdata = {16'd0, cfg_ff.one_end_count};
         CSR_GAP_END_COUNT:  csr_prdata = {16'd0, cfg_ff.gap_end_count};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_on      = rsp_led_ff;
   assign rsp_code_number = rsp_code_ff;

   // A new result only appears after a tick sat in the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a pending tick");

   // Input register is never overwritten while its tick waits
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !fire) |=> (s1_valid_ff && $stable(s1_flags_ff)))
      else $error("pending tick lost");

   // Code number of a result is the code step seen when it fired
   a_code_capture: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_code_ff == $past(code_now)))
      else $error("code number capture mismatch");

endmodule
